@@ rtl/nmea_rmc_field_extractor_assert.svh @@
// assertion macros for the rmc extractor
`ifndef NMEA_RMC_FIELD_EXTRACTOR_ASSERT_SVH
`define NMEA_RMC_FIELD_EXTRACTOR_ASSERT_SVH

// checked only while out of reset
`define NRFE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define NRFE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/nrfe_pkg.sv @@
`timescale 1ns / 1ps
package nrfe_pkg;

  localparam int BUFFER_BYTES    = 128;
  localparam int MAX_FIELD_CHARS = 12;
  localparam int TEXT_SLOTS      = 12;
  localparam int COMMA_LIMIT     = 10;
  localparam int QUEUE_DEPTH     = 2;
  localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_NEWLINE = 8'h0a;
  localparam logic [7:0] CH_COMMA   = 8'h2c;
  localparam logic [7:0] CH_A       = 8'h41;
  localparam logic [7:0] CH_G       = 8'h47;
  localparam logic [7:0] CH_R       = 8'h52;
  localparam logic [7:0] CH_M       = 8'h4d;
  localparam logic [7:0] CH_C       = 8'h43;

  localparam logic [7:0] POS_START = 8'd0;
  localparam logic [7:0] POS_G     = 8'd1;
  localparam logic [7:0] POS_R     = 8'd3;
  localparam logic [7:0] POS_M     = 8'd4;
  localparam logic [7:0] POS_C     = 8'd5;
  localparam logic [7:0] POS_MIN   = 8'd6;

  localparam logic [3:0] FIELD_STATUS = 4'd2;
  localparam logic [3:0] FIELD_LAT    = 4'd3;
  localparam logic [3:0] FIELD_LON    = 4'd5;

  typedef struct packed {
    logic [7:0] ch;
    logic       dollar;
    logic       comma;
    logic       newline;
    logic       is_a;
    logic       is_g;
    logic       is_r;
    logic       is_m;
    logic       is_c;
  } item_t;

endpackage

@@ rtl/nrfe_front.sv @@
`timescale 1ns / 1ps
module nrfe_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     in_rx_byte,
  output logic           q_valid,
  input  logic           q_ready,
  output nrfe_pkg::item_t q_item
);
  import nrfe_pkg::*;

  item_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  item_t             cls;
  logic              push, pop;

  always_comb begin
    cls.ch      = in_rx_byte;
    cls.dollar  = (in_rx_byte == CH_DOLLAR);
    cls.comma   = (in_rx_byte == CH_COMMA);
    cls.newline = (in_rx_byte == CH_NEWLINE);
    cls.is_a    = (in_rx_byte == CH_A);
    cls.is_g    = (in_rx_byte == CH_G);
    cls.is_r    = (in_rx_byte == CH_R);
    cls.is_m    = (in_rx_byte == CH_M);
    cls.is_c    = (in_rx_byte == CH_C);
  end

  assign in_ready = rst_n && (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign q_valid  = (cnt_r != '0);
  assign q_item   = mem_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= cls;
    end
  end

endmodule

@@ rtl/nrfe_back.sv @@
`timescale 1ns / 1ps
`include "nmea_rmc_field_extractor_assert.svh"
module nrfe_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  output logic            q_ready,
  input  nrfe_pkg::item_t q_item,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            out_fix_valid,
  output logic [63:0]     out_lat_text_low,
  output logic [31:0]     out_lat_text_high,
  output logic [3:0]      out_lat_length,
  output logic [63:0]     out_lon_text_low,
  output logic [31:0]     out_lon_text_high,
  output logic [3:0]      out_lon_length
);
  import nrfe_pkg::*;

  localparam int TW = 8 * TEXT_SLOTS;

  logic [7:0]    pos_r, pos_nxt;
  logic [3:0]    cc_r, cc_nxt;
  logic          hdr_r, hdr_nxt;
  logic          stat_r, stat_nxt;
  logic [TW-1:0] lat_r, lat_nxt;
  logic [3:0]    latn_r, latn_nxt;
  logic [TW-1:0] lon_r, lon_nxt;
  logic [3:0]    lonn_r, lonn_nxt;

  logic          out_valid_r;
  logic          fix_r;
  logic [TW-1:0] lat_o_r, lon_o_r;
  logic [3:0]    latl_r, lonl_r;

  logic pop, emit;
  logic [3:0] cc_inc;

  assign q_ready = !q_item.newline || !out_valid_r || out_ready;
  assign pop     = q_valid && q_ready;

  always_comb begin
    pos_nxt  = pos_r;
    cc_nxt   = cc_r;
    hdr_nxt  = hdr_r;
    stat_nxt = stat_r;
    lat_nxt  = lat_r;
    latn_nxt = latn_r;
    lon_nxt  = lon_r;
    lonn_nxt = lonn_r;
    cc_inc   = cc_r + 4'd1;
    emit     = 1'b0;
    if (pop) begin
      if (q_item.dollar) begin
        pos_nxt  = '0;
        cc_nxt   = '0;
        hdr_nxt  = 1'b0;
        stat_nxt = 1'b0;
        lat_nxt  = '0;
        latn_nxt = '0;
        lon_nxt  = '0;
        lonn_nxt = '0;
      end
      cc_inc = cc_nxt + 4'd1;
      if (pos_nxt < 8'(BUFFER_BYTES - 1)) begin
        if (pos_nxt == POS_START) begin
          hdr_nxt = 1'b1;
        end else if ((pos_nxt == POS_G && !q_item.is_g) ||
                     (pos_nxt == POS_R && !q_item.is_r) ||
                     (pos_nxt == POS_M && !q_item.is_m) ||
                     (pos_nxt == POS_C && !q_item.is_c)) begin
          hdr_nxt = 1'b0;
        end
        pos_nxt = pos_nxt + 8'd1;
        if (q_item.comma) begin
          if (cc_nxt < 4'(COMMA_LIMIT)) begin
            cc_nxt = cc_inc;
            if (cc_inc == FIELD_LAT) begin
              latn_nxt = '0;
            end
          end
        end else if (!q_item.newline) begin
          if (cc_nxt == FIELD_STATUS) begin
            if (latn_nxt == '0) begin
              stat_nxt = q_item.is_a;
              latn_nxt = 4'd1;
            end
          end else if (cc_nxt == FIELD_LAT) begin
            if (latn_nxt < 4'(MAX_FIELD_CHARS)) begin
              for (int k = 0; k < TEXT_SLOTS; k++) begin
                if (latn_r == 4'(k)) begin
                  lat_nxt[8*k +: 8] = q_item.ch;
                end
              end
              latn_nxt = latn_nxt + 4'd1;
            end
          end else if (cc_nxt == FIELD_LON) begin
            if (lonn_nxt < 4'(MAX_FIELD_CHARS)) begin
              for (int k = 0; k < TEXT_SLOTS; k++) begin
                if (lonn_r == 4'(k)) begin
                  lon_nxt[8*k +: 8] = q_item.ch;
                end
              end
              lonn_nxt = lonn_nxt + 4'd1;
            end
          end
        end
      end
      emit = q_item.newline && hdr_nxt && (pos_nxt >= POS_MIN);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      cc_r        <= '0;
      hdr_r       <= 1'b0;
      stat_r      <= 1'b0;
      lat_r       <= '0;
      latn_r      <= '0;
      lon_r       <= '0;
      lonn_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      cc_r   <= cc_nxt;
      hdr_r  <= hdr_nxt;
      stat_r <= stat_nxt;
      lat_r  <= lat_nxt;
      latn_r <= latn_nxt;
      lon_r  <= lon_nxt;
      lonn_r <= lonn_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      fix_r   <= stat_nxt;
      lat_o_r <= lat_nxt;
      lon_o_r <= lon_nxt;
      latl_r  <= (cc_nxt >= FIELD_LAT) ? latn_nxt : 4'd0;
      lonl_r  <= lonn_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_fix_valid     = fix_r;
  assign out_lat_text_low  = lat_o_r[63:0];
  assign out_lat_text_high = lat_o_r[TW-1:64];
  assign out_lat_length    = latl_r;
  assign out_lon_text_low  = lon_o_r[63:0];
  assign out_lon_text_high = lon_o_r[TW-1:64];
  assign out_lon_length    = lonl_r;

  `NRFE_ASSERT(a_no_overwrite, clk, rst_n, (out_valid_r && !out_ready) |-> !emit, "record overwritten before taken")
  `NRFE_ASSERT(a_dollar_restart, clk, rst_n, (pop && q_item.dollar) |=> (pos_r == 8'd1 && hdr_r), "dollar did not restart sentence")
  `NRFE_ASSERT(a_count_bound, clk, rst_n, (latn_r <= 4'(MAX_FIELD_CHARS)) && (lonn_r <= 4'(MAX_FIELD_CHARS)), "field count past limit")
  `NRFE_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_valid_r, "record present after reset")

endmodule

@@ rtl/nmea_rmc_field_extractor.sv @@
`timescale 1ns / 1ps
// a newline word is registered in the queue; its record shows on the registered out_valid once the parser pops it
// throughput: 1 byte per cycle, except while a newline waits on out_ready and the queue fills
// a 2-word queue between classifier and parser lets each side stall on its own
// reset: synchronous active-low rst_n clears sentence state, queue and output valid
// no clearing pass after reset, in_ready is held low while rst_n is low
module nmea_rmc_field_extractor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_fix_valid,
  output logic [63:0] out_lat_text_low,
  output logic [31:0] out_lat_text_high,
  output logic [3:0]  out_lat_length,
  output logic [63:0] out_lon_text_low,
  output logic [31:0] out_lon_text_high,
  output logic [3:0]  out_lon_length
);
  import nrfe_pkg::*;

  logic  q_valid, q_ready;
  item_t q_item;

  nrfe_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_item     (q_item)
  );

  nrfe_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_ready           (q_ready),
    .q_item            (q_item),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_fix_valid     (out_fix_valid),
    .out_lat_text_low  (out_lat_text_low),
    .out_lat_text_high (out_lat_text_high),
    .out_lat_length    (out_lat_length),
    .out_lon_text_low  (out_lon_text_low),
    .out_lon_text_high (out_lon_text_high),
    .out_lon_length    (out_lon_length)
  );

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
  import nrfe_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic        fix_valid;
    logic [63:0] lat_text_low;
    logic [31:0] lat_text_high;
    logic [3:0]  lat_length;
    logic [63:0] lon_text_low;
    logic [31:0] lon_text_high;
    logic [3:0]  lon_length;
  } rmc_record_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic        out_fix_valid;
  logic [63:0] out_lat_text_low;
  logic [31:0] out_lat_text_high;
  logic [3:0]  out_lat_length;
  logic [63:0] out_lon_text_low;
  logic [31:0] out_lon_text_high;
  logic [3:0]  out_lon_length;

  // sentence tracker state
  logic [7:0] sent_pos = '0;
  logic [3:0] comma_total = '0;
  logic       header_match = 1'b0;
  logic       fix_flag = 1'b0;
  logic [7:0] lat_buf [TEXT_SLOTS] = '{default: 8'h00};
  logic [3:0] lat_n = '0;
  logic [7:0] lon_buf [TEXT_SLOTS] = '{default: 8'h00};
  logic [3:0] lon_n = '0;

  rmc_record_t expected_records[$];

  int send_idle_pct;
  int recv_stall_pct;
  int cycle_count;
  int error_count = 0;
  int words_sent = 0;
  int sentences_sent = 0;
  int records_predicted = 0;
  int records_checked = 0;

  nmea_rmc_field_extractor u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_fix_valid     (out_fix_valid),
    .out_lat_text_low  (out_lat_text_low),
    .out_lat_text_high (out_lat_text_high),
    .out_lat_length    (out_lat_length),
    .out_lon_text_low  (out_lon_text_low),
    .out_lon_text_high (out_lon_text_high),
    .out_lon_length    (out_lon_length)
  );

  always #4 clk = ~clk;

  function automatic bit parse_rmc_byte(input logic [7:0] c, output rmc_record_t rec);
    logic [7:0] pos;
    rec = '0;
    if (c == CH_DOLLAR) begin
      sent_pos = '0;
      comma_total = '0;
      header_match = 1'b0;
      fix_flag = 1'b0;
      lat_buf = '{default: 8'h00};
      lon_buf = '{default: 8'h00};
      lat_n = '0;
      lon_n = '0;
    end
    if (sent_pos < BUFFER_BYTES - 1) begin
      pos = sent_pos;
      sent_pos = sent_pos + 8'd1;
      if (pos == POS_START) begin
        header_match = 1'b1;
      end else if ((pos == POS_G && c != CH_G) || (pos == POS_R && c != CH_R) ||
                   (pos == POS_M && c != CH_M) || (pos == POS_C && c != CH_C)) begin
        header_match = 1'b0;
      end
      if (c == CH_COMMA) begin
        if (comma_total < COMMA_LIMIT) begin
          comma_total = comma_total + 4'd1;
          if (comma_total == FIELD_LAT) lat_n = '0;
        end
      end else if (c != CH_NEWLINE) begin
        if (comma_total == FIELD_STATUS) begin
          // lat_n doubles as a seen-status marker inside the status field
          if (lat_n == 0) begin
            fix_flag = (c == CH_A);
            lat_n = 4'd1;
          end
        end else if (comma_total == FIELD_LAT) begin
          if (lat_n < MAX_FIELD_CHARS) begin
            lat_buf[lat_n] = c;
            lat_n = lat_n + 4'd1;
          end
        end else if (comma_total == FIELD_LON) begin
          if (lon_n < MAX_FIELD_CHARS) begin
            lon_buf[lon_n] = c;
            lon_n = lon_n + 4'd1;
          end
        end
      end
    end
    if (c == CH_NEWLINE && header_match && sent_pos >= POS_MIN) begin
      rec.fix_valid = fix_flag;
      for (int k = 0; k < 8; k++) begin
        rec.lat_text_low[8*k +: 8] = lat_buf[k];
        rec.lon_text_low[8*k +: 8] = lon_buf[k];
      end
      for (int k = 0; k < 4; k++) begin
        rec.lat_text_high[8*k +: 8] = lat_buf[8+k];
        rec.lon_text_high[8*k +: 8] = lon_buf[8+k];
      end
      rec.lat_length = (comma_total >= FIELD_LAT) ? lat_n : 4'd0;
      rec.lon_length = lon_n;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // enter and leave at a falling edge; valid stays high into the next word
  task automatic send_word(input logic [7:0] b);
    rmc_record_t rec;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      in_rx_byte <= 8'($urandom_range(0, 255));
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    if (parse_rmc_byte(b, rec)) begin
      expected_records.push_back(rec);
      records_predicted++;
    end
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i]);
  endtask

  function automatic logic [7:0] field_char();
    logic [7:0] c;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: c = 8'("0" + $urandom_range(0, 9));
      5: c = ".";
      6: c = $urandom_range(0, 1) ? "N" : "E";
      default: begin
        c = 8'($urandom_range(0, 255));
        while (c == CH_DOLLAR || c == CH_COMMA || c == CH_NEWLINE)
          c = 8'($urandom_range(0, 255));
      end
    endcase
    return c;
  endfunction

  task automatic send_random_sentence();
    logic [7:0] words[$];
    int kind;
    int n_fields;
    int len;
    kind = $urandom_range(0, 99);
    sentences_sent++;
    if (kind < 8) begin
      repeat ($urandom_range(1, 12)) words.push_back(8'($urandom_range(0, 255)));
    end else begin
      words.push_back(CH_DOLLAR);
      words.push_back(CH_G);
      words.push_back(field_char());
      words.push_back(CH_R);
      words.push_back(CH_M);
      words.push_back(CH_C);
      if (kind < 16) words[$urandom_range(1, 5)] = field_char();
      n_fields = $urandom_range(0, 13);
      for (int f = 1; f <= n_fields; f++) begin
        words.push_back(CH_COMMA);
        if (f == FIELD_STATUS) begin
          len = $urandom_range(0, 2);
          if (len > 0) begin
            words.push_back($urandom_range(0, 3) ? ($urandom_range(0, 1) ? CH_A : "V")
                                                : field_char());
            len--;
          end
        end else if ($urandom_range(0, 9) == 0) begin
          len = $urandom_range(10, 16);
        end else begin
          len = $urandom_range(0, 9);
        end
        repeat (len) words.push_back(field_char());
      end
      if (kind >= 97) repeat ($urandom_range(115, 140)) words.push_back(field_char());
      if ($urandom_range(0, 19) != 0) words.push_back(CH_NEWLINE);
      if ($urandom_range(0, 9) == 0) words.push_back(CH_NEWLINE);
    end
    foreach (words[i]) send_word(words[i]);
  endtask

  task automatic test_before_first_dollar();
    send_text("GGxRMC,1,A,22,,33\n");
  endtask

  task automatic test_well_formed();
    send_text("$GPRMC,123519,A,4807.038,N,01131.000,E\n");
    send_text("\n");
    send_text("$GNRMC,1,V,12,N,345,E\n");
    send_text("$GPRMC\n");
  endtask

  task automatic test_header_mismatch();
    send_text("$XPRMC,,A,1,,2\n");
    send_text("$GPXMC,,A,1,,2\n");
    send_text("$GPRXC,,A,1,,2\n");
    send_text("$GPRMX,,A,1,,2\n");
    send_text("$GPRM\n");
    send_text("$\n");
  endtask

  task automatic test_field_edges();
    send_text("$GPRMC,,,,,,\n");
    send_text("$GPRMC,1,A\n");
    send_text("$GPRMC,,A,0123456789ABCDE,N,FEDCBA9876543210,W\n");
    send_text("$GPRMC,,A,");
    send_word(8'h00);
    send_word(8'hff);
    send_text(",,");
    send_word(8'hff);
    send_word(8'h00);
    send_text("\n");
    send_text("$GPRMC,,A,1,,2,,,,,,,,,,,,,,9\n");
  endtask

  task automatic test_buffer_full();
    send_text("$GPRMC,,A,");
    repeat (140) send_word(field_char());
    send_text("\n");
    send_text("\n");
  endtask

  task automatic test_random(input int send_pct, input int recv_pct, input int target);
    int start_words;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    start_words = words_sent;
    while (words_sent - start_words < target)
      send_random_sentence();
  endtask

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    rmc_record_t exp_rec;
    if (rst_n && out_valid && out_ready) begin
      if (expected_records.size() == 0) begin
        $error("record with no expected record pending");
        error_count++;
      end else begin
        exp_rec = expected_records.pop_front();
        records_checked++;
        if (out_fix_valid !== exp_rec.fix_valid) begin
          $error("fix_valid expected %0h got %0h", exp_rec.fix_valid, out_fix_valid);
          error_count++;
        end
        if (out_lat_text_low !== exp_rec.lat_text_low) begin
          $error("lat_text_low expected %h got %h", exp_rec.lat_text_low, out_lat_text_low);
          error_count++;
        end
        if (out_lat_text_high !== exp_rec.lat_text_high) begin
          $error("lat_text_high expected %h got %h", exp_rec.lat_text_high, out_lat_text_high);
          error_count++;
        end
        if (out_lat_length !== exp_rec.lat_length) begin
          $error("lat_length expected %0d got %0d", exp_rec.lat_length, out_lat_length);
          error_count++;
        end
        if (out_lon_text_low !== exp_rec.lon_text_low) begin
          $error("lon_text_low expected %h got %h", exp_rec.lon_text_low, out_lon_text_low);
          error_count++;
        end
        if (out_lon_text_high !== exp_rec.lon_text_high) begin
          $error("lon_text_high expected %h got %h", exp_rec.lon_text_high, out_lon_text_high);
          error_count++;
        end
        if (out_lon_length !== exp_rec.lon_length) begin
          $error("lon_length expected %0d got %0d", exp_rec.lon_length, out_lon_length);
          error_count++;
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d records still pending", cycle_count,
             expected_records.size());
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_rx_byte = 8'h00;
    out_ready = 1'b0;
    send_idle_pct = 23;
    recv_stall_pct = 48;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_before_first_dollar();
    test_well_formed();
    test_header_mismatch();
    test_field_edges();
    test_buffer_full();
    test_random(23, 48, 250);
    test_random(48, 23, 250);
    test_random(0, 0, 250);

    in_valid <= 1'b0;
    while (expected_records.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("sent %0d words in %0d random sentences plus directed cases", words_sent,
             sentences_sent);
    $display("checked %0d of %0d predicted records, %0d mismatches", records_checked,
             records_predicted, error_count);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
